// ===== rtl/lkpd_pkg.sv =====
package lkpd_pkg;

    // ring and level table sizes
    localparam int WINDOW       = 4;
    localparam int LEVELS       = 16;
    localparam int SLOT_W       = $clog2(WINDOW);
    localparam int FILL_W       = $clog2(WINDOW + 1);

    // field widths
    localparam int SAMPLE_W     = 10;
    localparam int VALUE_W      = 8;
    localparam int SAMPLE_SHIFT = 2;
    localparam int KEY_W        = 4;
    localparam int TOL_W        = 8;

    localparam logic [TOL_W-1:0] TOL_RESET = 8'd8;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [WINDOW-1:0][VALUE_W-1:0] t_window;

    // ladder levels, entry 0 in the low byte
    localparam logic [15:0][VALUE_W-1:0] LEVEL_TABLE = {
        8'd0,   8'd15,  8'd32,  8'd48,
        8'd70,  8'd87,  8'd103, 8'd120,
        8'd137, 8'd152, 8'd168, 8'd180,
        8'd195, 8'd210, 8'd225, 8'd241
    };

    // control into the ring
    typedef struct packed {
        logic fire;
        logic start;
    } t_win_ctl;

    // decode of one window
    typedef struct packed {
        logic             stable;
        logic             pressed;
        logic [KEY_W-1:0] key;
    } t_match;

    function automatic t_value abs_diff(t_value a, t_value b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/ladder_keypad_number_decoder_core.sv =====
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+--------------------------------------
// sample   | in        | i_valid / o_stall    | i_sample, i_start_req
// result   | out       | o_valid / i_stall    | o_stable, o_pressed, o_key,
//          |           |                      | o_last_key, o_last_valid
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (tolerance)
//
// one word per cycle sustained while the result side is not stalled; an accepted word goes
// into the input register, then through ring update and decode into the result register
// the window compare and the 16-level table compare sit combinationally between the two
// synchronous active-low reset clears the ring, fill count, held key and tolerance to 8
// o_stall rises only when both registers are full and the result side is stalled
module ladder_keypad_number_decoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // sample channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lkpd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                        i_start_req,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_stable,
    output logic                        o_pressed,
    output logic [lkpd_pkg::KEY_W-1:0]  o_key,
    output logic [lkpd_pkg::KEY_W-1:0]  o_last_key,
    output logic                        o_last_valid,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lkpd_pkg::TOL_W-1:0]  i_cfg_data
);
    import lkpd_pkg::*;

    // tolerance register
    logic [TOL_W-1:0] r_tolerance;

    // input register
    logic   r_in_valid;
    t_value r_in_value;
    logic   r_in_start;

    // result register, last key fields double as held state
    logic             r_out_valid;
    logic             r_stable;
    logic             r_pressed;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_last_key;
    logic             r_last_valid;

    logic     advance;
    logic     in_take;
    t_win_ctl win_ctl;
    t_window  window;
    logic     was_full;
    t_match   match;

    // result slot frees when empty or being taken this edge
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    assign win_ctl.fire  = r_in_valid && advance;
    assign win_ctl.start = r_in_start;

    // the user must send config writes only while idle; the block does not enforce it, so always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tolerance <= i_cfg_data;
        end
    end

    // capture: keep only the top bits of the converter word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (win_ctl.fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_value <= i_sample[SAMPLE_W-1:SAMPLE_SHIFT];
            r_in_start <= i_start_req;
        end
    end

    lkpd_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (win_ctl),
        .i_value    (r_in_value),
        .o_window   (window),
        .o_was_full (was_full)
    );

    lkpd_match u_match (
        .i_window    (window),
        .i_was_full  (was_full),
        .i_tolerance (r_tolerance),
        .o_match     (match)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_last_key   <= '0;
            r_last_valid <= 1'b0;
        end else if (win_ctl.fire) begin
            r_out_valid <= 1'b1;
            if (match.pressed) begin
                r_last_key   <= match.key;
                r_last_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_ctl.fire) begin
            r_stable  <= match.stable;
            r_pressed <= match.pressed;
            r_key     <= match.key;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_stable     = r_stable;
    assign o_pressed    = r_pressed;
    assign o_key        = r_key;
    assign o_last_key   = r_last_key;
    assign o_last_valid = r_last_valid;

    // a press is only ever reported on a stable window
    a_press_needs_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressed |-> o_stable)
        else $error("press reported without a stable window");

    // a fresh press is held as the last key in the same word
    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressed |-> o_last_valid && (o_last_key == o_key))
        else $error("pressed key not held as last key");

    // key reads zero unless pressed
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pressed |-> (o_key == '0))
        else $error("key nonzero without a press");

    // input side only stalls when the whole pipe is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled with room in the pipe");

endmodule

// ===== rtl/lkpd_window.sv =====
module lkpd_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lkpd_pkg::t_win_ctl i_ctl,
    input  lkpd_pkg::t_value  i_value,
    output lkpd_pkg::t_window o_window,
    output logic              o_was_full
);
    import lkpd_pkg::*;

    t_window           r_store;
    logic [SLOT_W-1:0] r_slot;
    logic [FILL_W-1:0] r_fill;

    t_window           n_store;
    logic [SLOT_W-1:0] slot_eff;
    logic [FILL_W-1:0] fill_eff;
    logic [SLOT_W-1:0] n_slot;
    logic [FILL_W-1:0] n_fill;

    // a start request rewinds the ring before this word is stored
    always_comb begin
        slot_eff = i_ctl.start ? '0 : r_slot;
        fill_eff = i_ctl.start ? '0 : r_fill;
        n_store  = r_store;
        n_store[slot_eff] = i_value;
        n_slot   = (slot_eff == SLOT_W'(WINDOW - 1)) ? '0 : slot_eff + 1'b1;
        n_fill   = (fill_eff >= FILL_W'(WINDOW)) ? fill_eff : fill_eff + 1'b1;
    end

    assign o_window   = n_store;
    assign o_was_full = (fill_eff >= FILL_W'(WINDOW));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_slot  <= '0;
            r_fill  <= '0;
        end else if (i_ctl.fire) begin
            r_store <= n_store;
            r_slot  <= n_slot;
            r_fill  <= n_fill;
        end
    end

endmodule

// ===== rtl/lkpd_match.sv =====
module lkpd_match (
    input  lkpd_pkg::t_window        i_window,
    input  logic                     i_was_full,
    input  logic [lkpd_pkg::TOL_W-1:0] i_tolerance,
    output lkpd_pkg::t_match         o_match
);
    import lkpd_pkg::*;

    logic             all_close;
    logic             hit;
    logic [KEY_W-1:0] hit_key;

    // every slot against physical slot 0
    always_comb begin
        all_close = 1'b1;
        for (int j = 1; j < WINDOW; j++) begin
            if (abs_diff(i_window[0], i_window[j]) >= i_tolerance) begin
                all_close = 1'b0;
            end
        end
    end

    // lowest matching level wins, so scan from the top down
    always_comb begin
        hit     = 1'b0;
        hit_key = '0;
        for (int j = LEVELS - 1; j >= 0; j--) begin
            if (abs_diff(i_window[0], LEVEL_TABLE[j]) < i_tolerance) begin
                hit     = 1'b1;
                hit_key = KEY_W'(j);
            end
        end
    end

    always_comb begin
        o_match.stable  = i_was_full && all_close;
        o_match.pressed = o_match.stable && hit;
        o_match.key     = o_match.pressed ? hit_key : '0;
    end

endmodule
